// ===== src/nixm_pkg.sv =====
`default_nettype none

package nixm_pkg;

    localparam int VEC_LEN = 16;
    localparam int IDX_W   = 4;
    localparam int BYTE_W  = 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam idx_t LAST_IDX = IDX_W'(VEC_LEN - 1);

    // one-hot controller states
    typedef enum logic [9:0] {
        ST_LOAD      = 10'b00_0000_0001,
        ST_MIX0      = 10'b00_0000_0010,
        ST_MIX1      = 10'b00_0000_0100,
        ST_MIX2      = 10'b00_0000_1000,
        ST_MIX3      = 10'b00_0001_0000,
        ST_MIX4      = 10'b00_0010_0000,
        ST_MIX5      = 10'b00_0100_0000,
        ST_MIX6      = 10'b00_1000_0000,
        ST_EMIT_LD   = 10'b01_0000_0000,
        ST_EMIT_WAIT = 10'b10_0000_0000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic mix1;
        logic mix2;
        logic mix3;
        logic mix4;
        logic mix5;
        logic mix6;
        logic emit_ld;
        idx_t wr_idx;
        idx_t rd_idx;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== src/nixm_ctrl.sv =====
`default_nettype none

module nixm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output nixm_pkg::dp_cmd_t      cmd
);
    import nixm_pkg::*;

    state_t state_reg, state_next;
    idx_t   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        cmd.wr_idx = cnt_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_we = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX) begin
                        state_next = ST_MIX0;
                    end
                end
            end
            ST_MIX0: begin
                state_next = ST_MIX1;
            end
            ST_MIX1: begin
                cmd.mix1   = 1'b1;
                state_next = ST_MIX2;
            end
            ST_MIX2: begin
                cmd.mix2   = 1'b1;
                state_next = ST_MIX3;
            end
            ST_MIX3: begin
                cmd.mix3   = 1'b1;
                state_next = ST_MIX4;
            end
            ST_MIX4: begin
                cmd.mix4   = 1'b1;
                state_next = ST_MIX5;
            end
            ST_MIX5: begin
                cmd.mix5   = 1'b1;
                state_next = ST_MIX6;
            end
            ST_MIX6: begin
                cmd.mix6   = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = (cnt_reg == LAST_IDX) ? ST_EMIT_LD : ST_MIX1;
            end
            ST_EMIT_LD: begin
                cmd.emit_ld = 1'b1;
                state_next  = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (cnt_reg == LAST_IDX) ? ST_LOAD : ST_EMIT_LD;
                end
            end
            default: begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
        // the mask store, and the mix store outside the lookup steps, read at the index the counter is about to hold
        cmd.rd_idx = cnt_next;
    end

endmodule

`default_nettype wire

// ===== src/nixm_dp.sv =====
`default_nettype none

module nixm_dp (
    input  wire logic              aclk,
    input  wire nixm_pkg::dp_cmd_t cmd,
    input  wire nixm_pkg::byte_t   mask_byte,
    input  wire nixm_pkg::byte_t   seed_byte,
    input  wire nixm_pkg::byte_t   table_byte,
    output nixm_pkg::byte_t        mixed_byte,
    output nixm_pkg::idx_t         byte_index,
    output logic                   final_byte
);
    import nixm_pkg::*;

    byte_t mask_store_reg  [VEC_LEN];
    byte_t seed_store_reg  [VEC_LEN];
    byte_t table_store_reg [VEC_LEN];
    byte_t mix_store_reg   [VEC_LEN];

    byte_t mask_rd_reg, seed_rd_reg, table_rd_reg, mix_rd_reg;
    byte_t a_reg, c1_reg, c2_reg, c3_reg, c4_reg;
    byte_t mixed_reg;
    idx_t  index_reg;
    logic  final_reg;

    byte_t c1, c2, c3, c4;
    idx_t  mix_raddr, mix_waddr;
    byte_t mix_wdata;
    logic  mix_we;

    assign c1 = mask_rd_reg ^ mix_rd_reg;
    assign c2 = seed_rd_reg ^ a_reg;
    assign c3 = mix_rd_reg ^ a_reg;
    assign c4 = table_rd_reg ^ a_reg;

    // mix store address and write selection per step
    always_comb begin
        if (cmd.mix2) begin
            mix_raddr = c2[IDX_W-1:0];
        end else if (cmd.mix3) begin
            mix_raddr = c3[IDX_W-1:0];
        end else if (cmd.mix4) begin
            mix_raddr = c4[IDX_W-1:0];
        end else if (cmd.mix5) begin
            mix_raddr = c1_reg[IDX_W-1:0];
        end else begin
            mix_raddr = cmd.rd_idx;
        end

        mix_we = cmd.load_we | cmd.mix3 | cmd.mix4 | cmd.mix5 | cmd.mix6;
        if (cmd.mix3) begin
            mix_waddr = c2_reg[IDX_W-1:0];
            mix_wdata = mix_rd_reg ^ c1_reg;
        end else if (cmd.mix4) begin
            mix_waddr = c3_reg[IDX_W-1:0];
            mix_wdata = mix_rd_reg ^ c2_reg;
        end else if (cmd.mix5) begin
            mix_waddr = c4_reg[IDX_W-1:0];
            mix_wdata = mix_rd_reg ^ c3_reg;
        end else if (cmd.mix6) begin
            mix_waddr = c1_reg[IDX_W-1:0];
            mix_wdata = mix_rd_reg ^ c4_reg;
        end else begin
            mix_waddr = cmd.wr_idx;
            mix_wdata = seed_byte;
        end
    end

    // input vector stores
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            mask_store_reg[cmd.wr_idx]  <= mask_byte;
            seed_store_reg[cmd.wr_idx]  <= seed_byte;
            table_store_reg[cmd.wr_idx] <= table_byte;
        end
        mask_rd_reg  <= mask_store_reg[cmd.rd_idx];
        seed_rd_reg  <= seed_store_reg[c1[IDX_W-1:0]];
        table_rd_reg <= table_store_reg[c3[IDX_W-1:0]];
    end

    // mix store, write-first read so accumulating updates chain
    always_ff @(posedge aclk) begin
        if (mix_we) begin
            mix_store_reg[mix_waddr] <= mix_wdata;
        end
        if (mix_we && (mix_waddr == mix_raddr)) begin
            mix_rd_reg <= mix_wdata;
        end else begin
            mix_rd_reg <= mix_store_reg[mix_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mix1) begin
            a_reg  <= mask_rd_reg;
            c1_reg <= c1;
        end
        if (cmd.mix2) begin
            c2_reg <= c2;
        end
        if (cmd.mix3) begin
            c3_reg <= c3;
        end
        if (cmd.mix4) begin
            c4_reg <= c4;
        end
        if (cmd.emit_ld) begin
            mixed_reg <= mix_rd_reg;
            index_reg <= cmd.wr_idx;
            final_reg <= (cmd.wr_idx == LAST_IDX);
        end
    end

    assign mixed_byte = mixed_reg;
    assign byte_index = index_reg;
    assign final_byte = final_reg;

endmodule

`default_nettype wire

// ===== src/nibble_indexed_xor_mixer_top.sv =====
// nibble-indexed xor mixer
//
// input stream (s_): each word carries one byte of each of three 16-byte
// vectors, A (mask), B (seed) and C (table), in position order 0 to 15.
// s_tready is high only while the block is collecting words.
// after the sixteenth word the block mixes: O starts as B, then for each
// position four lookups and four xor updates of O run on a six-step
// sequencer (one step per cycle, the mix store taking one read and at most
// one write per step), after one setup step.
// output stream (m_): sixteen words, byte 0 first; m_tlast marks byte 15.
// each output byte is loaded into the output register (emit-load state) and
// then held valid (emit-wait state) until the receiver takes it.
// a receiver stall simply holds the current output word and the sequencer;
// no new input is taken until the sixteenth output word is delivered.
// reset (aresetn low, synchronous) returns to collecting at position 0;
// the vector stores hold no reset value and are always rewritten first.
`default_nettype none

module nibble_indexed_xor_mixer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input word
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // mask_byte [7:0], seed_byte [15:8], table_byte [23:16]
    // output word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // mixed_byte [7:0], byte_index [11:8], zero [15:12]
    output logic             m_tlast    // final_byte
);
    import nixm_pkg::*;

    dp_cmd_t cmd;
    byte_t   mixed_byte;
    idx_t    byte_index;
    logic    final_byte;

    // sequencer: collect, mix steps, emit
    nixm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // vector stores, mix arithmetic and output register
    nixm_dp u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .mask_byte  (s_tdata[7:0]),
        .seed_byte  (s_tdata[15:8]),
        .table_byte (s_tdata[23:16]),
        .mixed_byte (mixed_byte),
        .byte_index (byte_index),
        .final_byte (final_byte)
    );

    // pack the output word, padding up to whole bytes
    assign m_tdata = {4'b0000, byte_index, mixed_byte};
    assign m_tlast = final_byte;

endmodule

`default_nettype wire

// ===== src/nixm_checker.sv =====
`default_nettype none

module nixm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // collecting and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // last marker sits exactly on byte 15
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[11:8] == 4'hF)))
        else $error("last marker on wrong byte");

    // bytes come out in position order
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |-> ##2
            (m_tvalid && (m_tdata[11:8] == 4'($past(m_tdata[11:8], 2) + 4'd1))))
        else $error("output byte index out of order");

    // after the last byte the block collects again
    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("no return to collecting after last byte");

endmodule

bind nibble_indexed_xor_mixer_top nixm_checker u_nixm_checker (.*);

`default_nettype wire

// ===== dv/tb_nibble_indexed_xor_mixer_top.sv =====
module tb_nibble_indexed_xor_mixer_top;
    import nixm_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 300;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        byte_t value;
        idx_t  pos;
        logic  last;
    } out_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    nibble_indexed_xor_mixer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // predictor state: the three loaded vectors and the load position
    byte_t mask_vec [VEC_LEN];
    byte_t seed_vec [VEC_LEN];
    byte_t tbl_vec  [VEC_LEN];
    idx_t  load_pos = '0;

    out_word_t mixed_q [$];

    int err_count    = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_len     = 0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t timeout after %0d cycles", $time, CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // receiver ready, with an optional long hold-off counted here
    initial begin : rx_ready_gen
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : out_check
        out_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (mixed_q.size() == 0) begin
                err_count++;
                $display("%0t unexpected word: expected none, actual tdata %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                exp_w = mixed_q.pop_front();
                if (m_tdata[7:0] !== exp_w.value) begin
                    err_count++;
                    $display("%0t mixed_byte: expected %h, actual %h",
                             $time, exp_w.value, m_tdata[7:0]);
                end
                if (m_tdata[11:8] !== exp_w.pos) begin
                    err_count++;
                    $display("%0t byte_index: expected %h, actual %h",
                             $time, exp_w.pos, m_tdata[11:8]);
                end
                if (m_tdata[15:12] !== 4'h0) begin
                    err_count++;
                    $display("%0t tdata pad: expected 0, actual %h", $time, m_tdata[15:12]);
                end
                if (m_tlast !== exp_w.last) begin
                    err_count++;
                    $display("%0t final_byte: expected %b, actual %b",
                             $time, exp_w.last, m_tlast);
                end
            end
        end
    end

    // store one accepted word; on the sixteenth, mix and queue the output vector
    task automatic predict_mix(input byte_t m, input byte_t s, input byte_t t);
        byte_t     mixv [VEC_LEN];
        byte_t     a, c1, c2, c3, c4;
        out_word_t w;
        mask_vec[load_pos] = m;
        seed_vec[load_pos] = s;
        tbl_vec[load_pos]  = t;
        if (load_pos == LAST_IDX) begin
            for (int k = 0; k < VEC_LEN; k++) mixv[k] = seed_vec[k];
            for (int i = 0; i < VEC_LEN; i++) begin
                // all four lookups come before any update
                a  = mask_vec[i];
                c1 = a ^ mixv[i];
                c2 = seed_vec[c1[3:0]] ^ a;
                c3 = mixv[c2[3:0]] ^ a;
                c4 = tbl_vec[c3[3:0]] ^ a;
                mixv[c2[3:0]] ^= c1;
                mixv[c3[3:0]] ^= c2;
                mixv[c4[3:0]] ^= c3;
                mixv[c1[3:0]] ^= c4;
            end
            for (int k = 0; k < VEC_LEN; k++) begin
                w.value = mixv[k];
                w.pos   = idx_t'(k);
                w.last  = (k == VEC_LEN - 1);
                mixed_q.push_back(w);
            end
        end
        load_pos = load_pos + 1'b1;
    endtask

    task automatic send_word(input byte_t m, input byte_t s, input byte_t t);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, s, m};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_mix(m, s, t);
    endtask

    // narrow vectors keep low nibbles close together so indices collide often
    task automatic send_vector(input bit narrow);
        byte_t m, s, t;
        idx_t  base;
        int    span;
        base = idx_t'($urandom);
        span = narrow ? $urandom_range(2) : 15;
        for (int i = 0; i < VEC_LEN; i++) begin
            m = byte_t'($urandom);
            s = byte_t'($urandom);
            t = byte_t'($urandom);
            if (narrow) begin
                m[3:0] = base + idx_t'($urandom_range(span));
                s[3:0] = base + idx_t'($urandom_range(span));
                t[3:0] = base + idx_t'($urandom_range(span));
            end
            send_word(m, s, t);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mixed_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        byte_t m, s, t;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        for (int i = 0; i < VEC_LEN; i++) begin
            m = (i < 8) ? 8'h00 : 8'hFF;
            s = i[0] ? 8'hFF : 8'h00;
            t = byte_t'(i * 17);
            send_word(m, s, t);
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int vectors);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int v = 0; v < vectors; v++) send_vector($urandom_range(3) == 0);
    endtask

    // receiver holds off while the sender keeps offering the next vector
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_len     = LONG_HOLD;
        hold_req++;
        send_vector(1'b0);
        send_vector(1'b0);
        send_vector(1'b1);
        wait_drained();
    endtask

    // sender stops until every output word has come, then restarts
    task automatic test_drain_pause();
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        send_vector(1'b0);
        wait_drained();
        send_vector(1'b1);
        wait_drained();
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_random_phase(0, 0, 6);
        test_random_phase(78, 0, 6);
        test_random_phase(0, 78, 6);
        test_random_phase(17, 17, 6);
        test_backpressure();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mixed_q.size() != 0) begin
            err_count++;
            $display("%0t %0d output words never arrived", $time, mixed_q.size());
        end
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
